### rtl/core/swmf_pkg.sv
package swmf_pkg;

	localparam int MAX_WINDOW_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int                   WLEN_BITS  = 5;
	localparam logic [WLEN_BITS-1:0] WLEN_RESET = 5'd5;

endpackage

### rtl/core/sliding_window_median_filter_unit.sv
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------
// input     | in        | in_valid / in_stall    | sample [SAMPLE_BITS]
// output    | out       | out_valid / out_stall  | median [SAMPLE_BITS]
// config    | in        | cfg_valid / cfg_ready  | window_length [5]
//
// Per item, with len the effective window length (1 to MAX_WINDOW), the block runs:
// the accept cycle writes the history, then each window entry is ranked in turn on the
// shared comparator row, then the median is formed into the output register.
// The next item is accepted as soon as the result sits in the output register.
// arst_n clears the history, the write slot, the window length (to 5) and the handshakes.
// A stalled result holds in the output register and holds the finish; cfg_valid stalls input.
module sliding_window_median_filter_unit #(
	parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [SAMPLE_BITS-1:0]         sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [SAMPLE_BITS-1:0]         median,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [swmf_pkg::WLEN_BITS-1:0] window_length
);
	import swmf_pkg::*;

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RANK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]             state_q;
	logic [WLEN_BITS-1:0]   wlen_q;
	logic [SAMPLE_BITS-1:0] hist_q [MAX_WINDOW];
	logic [IDX_W-1:0]       slot_q;
	logic [IDX_W-1:0]       idx_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic [SAMPLE_BITS-1:0] median_q;
	logic                   out_valid_q;

	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       half;
	logic [LEN_W-1:0]       half_m1;
	logic [IDX_W-1:0]       slot_wr;
	logic [LEN_W-1:0]       slot_inc;
	logic [IDX_W-1:0]       slot_nx;
	logic [SAMPLE_BITS-1:0] cand;
	logic [LEN_W-1:0]       rank;
	logic [SAMPLE_BITS:0]   pair_sum;
	logic                   in_acc;
	logic                   out_free;

	always_comb begin
		if (wlen_q == '0) begin
			len = LEN_W'(1);
		end else if (int'(wlen_q) > MAX_WINDOW) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(wlen_q);
		end
	end

	assign half    = len >> 1;
	assign half_m1 = half - 1'b1;

	// drop a stale slot that lies beyond the window, then advance with wrap
	assign slot_wr  = (LEN_W'(slot_q) < len) ? slot_q : '0;
	assign slot_inc = LEN_W'(slot_wr) + 1'b1;
	assign slot_nx  = (slot_inc >= len) ? '0 : IDX_W'(slot_inc);

	assign cand = hist_q[idx_q];

	// rank of the candidate: smaller entries, plus equal ones at lower slots
	always_comb begin
		rank = '0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			if (LEN_W'(j) < len) begin
				if ((hist_q[j] < cand) ||
				    ((hist_q[j] == cand) && (LEN_W'(j) < LEN_W'(idx_q)))) begin
					rank = rank + 1'b1;
				end
			end
		end
	end

	assign pair_sum = {1'b0, lo_q} + {1'b0, hi_q};

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign median    = median_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wlen_q      <= WLEN_RESET;
			slot_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_WINDOW; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			// load a finished result or drop a taken one
			if (out_free) begin
				out_valid_q <= (state_q == ST_DONE);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						wlen_q <= window_length;
						slot_q <= '0;
						for (int i = 0; i < MAX_WINDOW; i++) begin
							hist_q[i] <= '0;
						end
					end else if (in_acc) begin
						hist_q[slot_wr] <= sample;
						slot_q          <= slot_nx;
						idx_q           <= '0;
						state_q         <= ST_RANK;
					end
				end
				ST_RANK: begin
					if (LEN_W'(idx_q) == len - 1'b1) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// middle pair of the sorted window, picked by rank
	always_ff @(posedge clk) begin
		if (state_q == ST_RANK) begin
			if (rank == half_m1) begin
				lo_q <= cand;
			end
			if (rank == half) begin
				hi_q <= cand;
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			median_q <= len[0] ? hi_q : pair_sum[SAMPLE_BITS:1];
		end
	end

endmodule

### rtl/core/swmf_check.sv
module swmf_check #(
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [SAMPLE_BITS-1:0]         sample,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [SAMPLE_BITS-1:0]         median,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [swmf_pkg::WLEN_BITS-1:0] window_length
);
	import swmf_pkg::*;

	// an accepted item keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted item");

	// a new result comes only out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without preceding work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(median)))
		else $error("stalled result changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> $stable(sample))
		else $error("stalled sample changed");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && !cfg_ready) |=> $stable(window_length))
		else $error("pending window length changed");

endmodule

bind sliding_window_median_filter_unit swmf_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_swmf_check (.*);
